// ===== rtl/core/ucrr_pkg.sv =====
`timescale 1ns / 1ps

package ucrr_pkg;

    // endpoint zero packet size reported in the device descriptor
    localparam int unsigned EP0_MAX_PACKET = 64;

    // response kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_DATA      = 2'd0;
    localparam t_kind KIND_ZLP       = 2'd1;
    localparam t_kind KIND_STALL     = 2'd2;
    localparam t_kind KIND_UNHANDLED = 2'd3;

    // byte source for the response stream
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_NONE   = 2'd0;
    localparam t_sel SEL_STATUS = 2'd1;
    localparam t_sel SEL_DEVICE = 2'd2;
    localparam t_sel SEL_CONFIG = 2'd3;

    // setup packet codes
    localparam logic [7:0] RT_STD_OUT      = 8'h00;
    localparam logic [7:0] RT_STD_IN       = 8'h80;
    localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
    localparam logic [7:0] REQ_GET_DESC    = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
    localparam logic [15:0] DESC_DEVICE    = 16'h0100;
    localparam logic [15:0] DESC_CONFIG    = 16'h0200;

    // descriptor lengths and counter widths
    localparam int unsigned DEV_DESC_LEN = 18;
    localparam int unsigned CFG_DESC_LEN = 9 + 9 + 2 * 7;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned CNT_W        = 6;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_VENDOR  = 2'd0;
    localparam t_cfg_idx CFG_PRODUCT = 2'd1;
    localparam t_cfg_idx CFG_RELEASE = 2'd2;

    localparam logic [15:0] VENDOR_RESET  = 16'hF055;
    localparam logic [15:0] PRODUCT_RESET = 16'h0125;
    localparam logic [15:0] RELEASE_RESET = 16'h0000;

    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [15:0] device_release;
    } t_dev_ids;

    // fixed configuration descriptor: config, interface, two bulk endpoints
    function automatic logic [7:0] cfg_desc_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            5'd0:    b = 8'd9;
            5'd1:    b = 8'd2;
            5'd2:    b = 8'(CFG_DESC_LEN);
            5'd4:    b = 8'd1;
            5'd7:    b = 8'h80;
            5'd8:    b = 8'd50;
            5'd9:    b = 8'd9;
            5'd10:   b = 8'd4;
            5'd13:   b = 8'd2;
            5'd14:   b = 8'hff;
            5'd15:   b = 8'hff;
            5'd16:   b = 8'hff;
            5'd18:   b = 8'd7;
            5'd19:   b = 8'd5;
            5'd20:   b = 8'h81;
            5'd21:   b = 8'h02;
            5'd22:   b = 8'd64;
            5'd24:   b = 8'd1;
            5'd25:   b = 8'd7;
            5'd26:   b = 8'd5;
            5'd27:   b = 8'h02;
            5'd28:   b = 8'h02;
            5'd29:   b = 8'd64;
            5'd31:   b = 8'd1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/ucrr_desc_rom.sv =====
`timescale 1ns / 1ps

module ucrr_desc_rom (
    input  ucrr_pkg::t_sel                 i_sel,
    input  logic [ucrr_pkg::IDX_W-1:0]     i_idx,
    input  ucrr_pkg::t_dev_ids             i_ids,
    output logic [7:0]                     o_byte
);

    logic [7:0] w_dev_byte;
    logic [7:0] w_max_pkt;

    assign w_max_pkt = 8'(ucrr_pkg::EP0_MAX_PACKET);

    // device descriptor with the programmable id fields
    always_comb begin
        case (i_idx)
            5'd0:    w_dev_byte = 8'(ucrr_pkg::DEV_DESC_LEN);
            5'd1:    w_dev_byte = 8'd1;
            5'd3:    w_dev_byte = 8'd2;
            5'd4:    w_dev_byte = 8'hff;
            5'd5:    w_dev_byte = 8'hff;
            5'd6:    w_dev_byte = 8'hff;
            5'd7:    w_dev_byte = w_max_pkt;
            5'd8:    w_dev_byte = i_ids.vendor_id[7:0];
            5'd9:    w_dev_byte = i_ids.vendor_id[15:8];
            5'd10:   w_dev_byte = i_ids.product_id[7:0];
            5'd11:   w_dev_byte = i_ids.product_id[15:8];
            5'd12:   w_dev_byte = i_ids.device_release[7:0];
            5'd13:   w_dev_byte = i_ids.device_release[15:8];
            5'd17:   w_dev_byte = 8'd1;
            default: w_dev_byte = 8'h00;
        endcase
    end

    // source select; status bytes and non-data results read as zero
    always_comb begin
        case (i_sel)
            ucrr_pkg::SEL_DEVICE: o_byte = w_dev_byte;
            ucrr_pkg::SEL_CONFIG: o_byte = ucrr_pkg::cfg_desc_byte(i_idx);
            default:              o_byte = 8'h00;
        endcase
    end

endmodule

// ===== rtl/core/usb_control_request_responder_unit.sv =====
`timescale 1ns / 1ps

// Standard control request responder for endpoint zero. Each input transfer is a decoded
// setup packet or a bus reset event; the block answers set address, get status, get
// descriptor (device or configuration) and set configuration, and streams one result per
// cycle while the result channel is not stalled, the final one flagged by o_last; the
// byte counter steps the descriptor ROM, and a 32-byte configuration descriptor is the
// longest answer. No new setup is taken before the last result is loaded. Vendor id,
// product id and device release are written through the configuration port, which is
// always ready; the user writes them only while the block is idle; it is not enforced.
module usb_control_request_responder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // setup channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic [15:0] i_request_length,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_response_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic [6:0]  o_device_address,
    output logic        o_configured,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          r_state, n_state;
    ucrr_pkg::t_sel                r_sel, n_sel;
    ucrr_pkg::t_kind               r_kind, n_kind;
    logic [ucrr_pkg::CNT_W-1:0]    r_count, n_count;
    logic [ucrr_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [6:0]                    r_addr, n_addr;
    logic                          r_cfgd, n_cfgd;
    ucrr_pkg::t_dev_ids            r_ids;

    logic                          r_out_valid, n_out_valid;
    ucrr_pkg::t_kind               r_out_kind, n_out_kind;
    logic [7:0]                    r_out_byte, n_out_byte;
    logic                          r_out_last, n_out_last;
    logic [6:0]                    r_out_addr, n_out_addr;
    logic                          r_out_cfgd, n_out_cfgd;

    logic                          w_in_xfer;
    logic                          w_load;
    logic                          w_is_last;
    logic [7:0]                    w_rom_byte;
    logic [15:0]                   w_dlen;
    logic                          w_desc_ok;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_load      = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign w_is_last   = (({1'b0, r_idx} + 6'd1) == r_count);
    assign o_cfg_ready = 1'b1;

    ucrr_desc_rom u_rom (
        .i_sel  (r_sel),
        .i_idx  (r_idx),
        .i_ids  (r_ids),
        .o_byte (w_rom_byte)
    );

    // descriptor length lookup
    always_comb begin
        w_desc_ok = 1'b1;
        w_dlen    = 16'(ucrr_pkg::CFG_DESC_LEN);
        if (i_request_value == ucrr_pkg::DESC_DEVICE) begin
            w_dlen = 16'(ucrr_pkg::DEV_DESC_LEN);
        end else if (i_request_value != ucrr_pkg::DESC_CONFIG) begin
            w_desc_ok = 1'b0;
        end
    end

    // request decode and result sequencer
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_kind      = r_kind;
        n_count     = r_count;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_cfgd      = r_cfgd;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_addr  = r_out_addr;
        n_out_cfgd  = r_out_cfgd;

        if (w_in_xfer) begin
            n_state = ST_EMIT;
            n_idx   = '0;
            n_sel   = ucrr_pkg::SEL_NONE;
            n_count = 6'd1;
            n_kind  = ucrr_pkg::KIND_UNHANDLED;
            if (i_command) begin
                n_addr = 7'd0;
                n_kind = ucrr_pkg::KIND_ZLP;
            end else if (i_request_type == ucrr_pkg::RT_STD_OUT &&
                         i_request_code == ucrr_pkg::REQ_SET_ADDRESS) begin
                n_addr = i_request_value[6:0];
                n_kind = ucrr_pkg::KIND_ZLP;
            end else if (i_request_type == ucrr_pkg::RT_STD_IN &&
                         i_request_code == ucrr_pkg::REQ_GET_STATUS) begin
                n_sel   = ucrr_pkg::SEL_STATUS;
                n_kind  = ucrr_pkg::KIND_DATA;
                n_count = 6'd2;
            end else if (i_request_type == ucrr_pkg::RT_STD_IN &&
                         i_request_code == ucrr_pkg::REQ_GET_DESC) begin
                if (!w_desc_ok) begin
                    n_kind = ucrr_pkg::KIND_STALL;
                end else if (i_request_length == 16'd0) begin
                    n_kind = ucrr_pkg::KIND_ZLP;
                end else begin
                    n_kind  = ucrr_pkg::KIND_DATA;
                    n_sel   = (i_request_value == ucrr_pkg::DESC_DEVICE) ?
                              ucrr_pkg::SEL_DEVICE : ucrr_pkg::SEL_CONFIG;
                    n_count = (i_request_length < w_dlen) ?
                              i_request_length[ucrr_pkg::CNT_W-1:0] :
                              w_dlen[ucrr_pkg::CNT_W-1:0];
                end
            end else if (i_request_type == ucrr_pkg::RT_STD_OUT &&
                         i_request_code == ucrr_pkg::REQ_SET_CONFIG) begin
                if (i_request_value != 16'd0) begin
                    n_kind = ucrr_pkg::KIND_STALL;
                end else begin
                    n_cfgd = 1'b1;
                    n_kind = ucrr_pkg::KIND_ZLP;
                end
            end
        end

        // one result per free output slot
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_kind  = r_kind;
            n_out_byte  = w_rom_byte;
            n_out_last  = w_is_last;
            n_out_addr  = r_addr;
            n_out_cfgd  = r_cfgd;
            n_idx       = r_idx + 5'd1;
            if (w_is_last) begin
                n_state = ST_IDLE;
            end
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_addr      <= 7'd0;
            r_cfgd      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
            r_cfgd      <= n_cfgd;
        end
    end

    // sequencer and output payload
    always_ff @(posedge i_clk) begin
        r_sel      <= n_sel;
        r_kind     <= n_kind;
        r_count    <= n_count;
        r_idx      <= n_idx;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_addr <= n_out_addr;
        r_out_cfgd <= n_out_cfgd;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids.vendor_id      <= ucrr_pkg::VENDOR_RESET;
            r_ids.product_id     <= ucrr_pkg::PRODUCT_RESET;
            r_ids.device_release <= ucrr_pkg::RELEASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ucrr_pkg::CFG_VENDOR:  r_ids.vendor_id      <= i_cfg_data;
                ucrr_pkg::CFG_PRODUCT: r_ids.product_id     <= i_cfg_data;
                ucrr_pkg::CFG_RELEASE: r_ids.device_release <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_response_kind  = r_out_kind;
    assign o_data_byte      = r_out_byte;
    assign o_last           = r_out_last;
    assign o_device_address = r_out_addr;
    assign o_configured     = r_out_cfgd;

endmodule

// ===== rtl/core/ucrr_checker.sv =====
`timescale 1ns / 1ps

module ucrr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic [15:0] i_request_length,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_response_kind,
    input  logic [7:0]  o_data_byte,
    input  logic        o_last,
    input  logic [6:0]  o_device_address,
    input  logic        o_configured,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // non-data answers are single results
    a_single_nondata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_response_kind != ucrr_pkg::KIND_DATA) |-> o_last)
        else $error("non-data result without last");

    // non-data results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_response_kind != ucrr_pkg::KIND_DATA) |-> (o_data_byte == 8'h00))
        else $error("non-data result with nonzero byte");

    // device state holds inside one answer
    a_state_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |=> ($stable(o_device_address) && $stable(o_configured)))
        else $error("device state changed within an answer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_data_byte) && $stable(o_response_kind) && $stable(o_last)))
        else $error("stalled result dropped or changed");

endmodule

bind usb_control_request_responder_unit ucrr_checker u_ucrr_checker (.*);

// ===== bench/tb_usb_control_request_responder_unit.sv =====
`timescale 1ns / 1ps

module tb_usb_control_request_responder_unit;

    localparam int unsigned DIRECTED_ROWS  = 25;
    localparam int unsigned PHASES         = 5;
    localparam int unsigned ITEMS_PER_PHASE = 94;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned TAIL_CYCLES    = 40;

    // configuration descriptor image, byte 0 in the top bits
    localparam logic [8*ucrr_pkg::CFG_DESC_LEN-1:0] CONFIG_IMAGE = {
        8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h00, 8'h00, 8'h80, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h01,
        8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h01
    };

    typedef struct packed {
        logic        cmd;
        logic [7:0]  rtype;
        logic [7:0]  rcode;
        logic [15:0] req_value;
        logic [15:0] req_length;
    } t_setup;

    typedef struct packed {
        ucrr_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
        logic [6:0]      addr;
        logic            conf;
    } t_answer;

    // one stimulus line; typed rows carry their single answer written out by hand
    typedef struct packed {
        t_setup          pkt;
        logic            typed;
        ucrr_pkg::t_kind kind;
        logic [6:0]      addr;
        logic            conf;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [7:0]  i_request_type;
    logic [7:0]  i_request_code;
    logic [15:0] i_request_value;
    logic [15:0] i_request_length;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_response_kind;
    logic [7:0]  o_data_byte;
    logic        o_last;
    logic [6:0]  o_device_address;
    logic        o_configured;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // predictor state
    ucrr_pkg::t_dev_ids model_ids;
    logic [6:0]  model_addr;
    logic        model_configured;

    t_answer     pending_answers[$];
    t_answer     fresh_answers[$];
    t_answer     oldest;
    t_row        cur_row;
    int unsigned mismatches;
    logic        no_gaps;
    logic        hold_request;

    usb_control_request_responder_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_request_type   (i_request_type),
        .i_request_code   (i_request_code),
        .i_request_value  (i_request_value),
        .i_request_length (i_request_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_response_kind  (o_response_kind),
        .o_data_byte      (o_data_byte),
        .o_last           (o_last),
        .o_device_address (o_device_address),
        .o_configured     (o_configured),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_answer answer(input ucrr_pkg::t_kind kind, input logic [7:0] data,
                                       input logic last, input logic [6:0] addr,
                                       input logic conf);
        t_answer a;
        a.kind = kind;
        a.data = data;
        a.last = last;
        a.addr = addr;
        a.conf = conf;
        return a;
    endfunction

    function automatic t_row row(input logic cmd, input logic [7:0] rtype,
                                 input logic [7:0] rcode, input logic [15:0] req_value,
                                 input logic [15:0] req_length, input logic typed,
                                 input ucrr_pkg::t_kind kind, input logic [6:0] addr,
                                 input logic conf);
        t_row r;
        r.pkt.cmd        = cmd;
        r.pkt.rtype      = rtype;
        r.pkt.rcode      = rcode;
        r.pkt.req_value  = req_value;
        r.pkt.req_length = req_length;
        r.typed          = typed;
        r.kind           = kind;
        r.addr           = addr;
        r.conf           = conf;
        return r;
    endfunction

    // device descriptor byte under the current ids
    function automatic logic [7:0] device_byte(input int unsigned idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            0:  b = 8'(ucrr_pkg::DEV_DESC_LEN);
            1:  b = 8'h01;
            3:  b = 8'h02;
            4, 5, 6: b = 8'hff;
            7:  b = 8'(ucrr_pkg::EP0_MAX_PACKET);
            8:  b = model_ids.vendor_id[7:0];
            9:  b = model_ids.vendor_id[15:8];
            10: b = model_ids.product_id[7:0];
            11: b = model_ids.product_id[15:8];
            12: b = model_ids.device_release[7:0];
            13: b = model_ids.device_release[15:8];
            17: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // update address and configured state, then list the answers of one setup transfer
    function automatic void predict_answers(input t_setup p);
        ucrr_pkg::t_sel  src;
        ucrr_pkg::t_kind lone_kind;
        int unsigned     span;
        int unsigned     count;
        logic [7:0]      b;
        src       = ucrr_pkg::SEL_NONE;
        lone_kind = ucrr_pkg::KIND_UNHANDLED;
        span      = 0;
        count     = 0;
        fresh_answers.delete();
        if (p.cmd) begin
            model_addr = '0;
            lone_kind  = ucrr_pkg::KIND_ZLP;
        end else if (p.rtype == ucrr_pkg::RT_STD_OUT &&
                     p.rcode == ucrr_pkg::REQ_SET_ADDRESS) begin
            model_addr = p.req_value[6:0];
            lone_kind  = ucrr_pkg::KIND_ZLP;
        end else if (p.rtype == ucrr_pkg::RT_STD_IN &&
                     p.rcode == ucrr_pkg::REQ_GET_STATUS) begin
            src   = ucrr_pkg::SEL_STATUS;
            count = 2;
        end else if (p.rtype == ucrr_pkg::RT_STD_IN &&
                     p.rcode == ucrr_pkg::REQ_GET_DESC) begin
            if (p.req_value == ucrr_pkg::DESC_DEVICE) begin
                src  = ucrr_pkg::SEL_DEVICE;
                span = ucrr_pkg::DEV_DESC_LEN;
            end else if (p.req_value == ucrr_pkg::DESC_CONFIG) begin
                src  = ucrr_pkg::SEL_CONFIG;
                span = ucrr_pkg::CFG_DESC_LEN;
            end else begin
                lone_kind = ucrr_pkg::KIND_STALL;
            end
            // truncate to the host length, zero length gives a status packet
            if (span != 0) begin
                count     = (32'(p.req_length) < span) ? 32'(p.req_length) : span;
                lone_kind = ucrr_pkg::KIND_ZLP;
            end
        end else if (p.rtype == ucrr_pkg::RT_STD_OUT &&
                     p.rcode == ucrr_pkg::REQ_SET_CONFIG) begin
            if (p.req_value != 16'h0000) begin
                lone_kind = ucrr_pkg::KIND_STALL;
            end else begin
                model_configured = 1'b1;
                lone_kind        = ucrr_pkg::KIND_ZLP;
            end
        end
        if (count == 0) begin
            fresh_answers.push_back(answer(lone_kind, 8'h00, 1'b1, model_addr,
                                           model_configured));
        end else begin
            for (int unsigned i = 0; i < count; i++) begin
                case (src)
                    ucrr_pkg::SEL_DEVICE: b = device_byte(i);
                    ucrr_pkg::SEL_CONFIG:
                        b = CONFIG_IMAGE[8*(ucrr_pkg::CFG_DESC_LEN-1-i) +: 8];
                    default:    b = 8'h00;
                endcase
                fresh_answers.push_back(answer(ucrr_pkg::KIND_DATA, b, i + 1 == count,
                                               model_addr, model_configured));
            end
        end
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // track config writes, predict on setup transfers, check result transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_ids.vendor_id      = ucrr_pkg::VENDOR_RESET;
            model_ids.product_id     = ucrr_pkg::PRODUCT_RESET;
            model_ids.device_release = ucrr_pkg::RELEASE_RESET;
            model_addr               = '0;
            model_configured         = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ucrr_pkg::CFG_VENDOR:  model_ids.vendor_id      = i_cfg_data;
                    ucrr_pkg::CFG_PRODUCT: model_ids.product_id     = i_cfg_data;
                    ucrr_pkg::CFG_RELEASE: model_ids.device_release = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_answers(cur_row.pkt);
                if (cur_row.typed) begin
                    pending_answers.push_back(answer(cur_row.kind, 8'h00, 1'b1,
                                                     cur_row.addr, cur_row.conf));
                end else begin
                    foreach (fresh_answers[i]) pending_answers.push_back(fresh_answers[i]);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual kind %0h data %0h",
                             $time, o_response_kind, o_data_byte);
                end else begin
                    oldest = pending_answers.pop_front();
                    check_field("response_kind", 8'(oldest.kind), 8'(o_response_kind));
                    check_field("data_byte", oldest.data, o_data_byte);
                    check_field("last", 8'(oldest.last), 8'(o_last));
                    check_field("device_address", 8'(oldest.addr), 8'(o_device_address));
                    check_field("configured", 8'(oldest.conf), 8'(o_configured));
                end
            end
        end
    end

    // result side: random stalls, or one long hold-off when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready <= no_gaps || ($urandom_range(99) >= 26);
            end
        end
    end

    // hand-written requests: extremes, each request and each corner
    function automatic t_row directed_row(input int unsigned k);
        t_row r;
        r = '0;
        case (k)
            0:  r = row(1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000,
                        1'b1, ucrr_pkg::KIND_ZLP, 7'h00, 1'b0);
            1:  r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_STATUS,
                        16'h0000, 16'h0000, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            2:  r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_STATUS,
                        16'hffff, 16'hffff, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            3:  r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS,
                        16'hffff, 16'h0000, 1'b1, ucrr_pkg::KIND_ZLP, 7'h7f, 1'b0);
            4:  r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_DEVICE, 16'hffff,
                        1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            5:  r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS,
                        16'h0000, 16'h0000, 1'b1, ucrr_pkg::KIND_ZLP, 7'h00, 1'b0);
            6:  r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS,
                        16'h01ab, 16'hffff, 1'b1, ucrr_pkg::KIND_ZLP, 7'h2b, 1'b0);
            7:  r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_DEVICE, 16'h0000,
                        1'b1, ucrr_pkg::KIND_ZLP, 7'h2b, 1'b0);
            8:  r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_DEVICE, 16'h0001,
                        1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            9:  r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_DEVICE, 16'h0011,
                        1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            10: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_CONFIG, 16'hffff,
                        1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            11: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_CONFIG, 16'h001f,
                        1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            12: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_CONFIG, 16'h0000,
                        1'b1, ucrr_pkg::KIND_ZLP, 7'h2b, 1'b0);
            13: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        16'h0300, 16'h0028, 1'b1, ucrr_pkg::KIND_STALL, 7'h2b, 1'b0);
            14: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        16'hffff, 16'hffff, 1'b1, ucrr_pkg::KIND_STALL, 7'h2b, 1'b0);
            15: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        16'h0101, 16'h0012, 1'b1, ucrr_pkg::KIND_STALL, 7'h2b, 1'b0);
            16: r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIG,
                        16'h0001, 16'h0000, 1'b1, ucrr_pkg::KIND_STALL, 7'h2b, 1'b0);
            17: r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIG,
                        16'h8000, 16'hffff, 1'b1, ucrr_pkg::KIND_STALL, 7'h2b, 1'b0);
            18: r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIG,
                        16'h0000, 16'h0000, 1'b1, ucrr_pkg::KIND_ZLP, 7'h2b, 1'b1);
            19: r = row(1'b0, 8'hff, 8'hff, 16'hffff, 16'hffff,
                        1'b1, ucrr_pkg::KIND_UNHANDLED, 7'h2b, 1'b1);
            20: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_SET_ADDRESS,
                        16'h0011, 16'h0000, 1'b1, ucrr_pkg::KIND_UNHANDLED, 7'h2b, 1'b1);
            21: r = row(1'b0, ucrr_pkg::RT_STD_OUT, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_DEVICE, 16'h0012,
                        1'b1, ucrr_pkg::KIND_UNHANDLED, 7'h2b, 1'b1);
            22: r = row(1'b0, 8'h01, ucrr_pkg::REQ_SET_CONFIG, 16'h0000, 16'h0000,
                        1'b1, ucrr_pkg::KIND_UNHANDLED, 7'h2b, 1'b1);
            23: r = row(1'b1, 8'hff, 8'hff, 16'hffff, 16'hffff,
                        1'b1, ucrr_pkg::KIND_ZLP, 7'h00, 1'b1);
            24: r = row(1'b0, ucrr_pkg::RT_STD_IN, ucrr_pkg::REQ_GET_DESC,
                        ucrr_pkg::DESC_CONFIG, 16'h0020,
                        1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0);
            default: r = '0;
        endcase
        return r;
    endfunction

    // mostly well-formed requests with random content, some bus resets and noise
    function automatic t_row random_row();
        t_row        r;
        int unsigned pick;
        r = '0;
        r.pkt.rtype      = 8'($urandom);
        r.pkt.rcode      = 8'($urandom);
        r.pkt.req_value  = 16'($urandom);
        r.pkt.req_length = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 10) begin
            r.pkt.cmd = 1'b1;
        end else if (pick < 25) begin
            r.pkt.rtype = ucrr_pkg::RT_STD_OUT;
            r.pkt.rcode = ucrr_pkg::REQ_SET_ADDRESS;
        end else if (pick < 35) begin
            r.pkt.rtype = ucrr_pkg::RT_STD_IN;
            r.pkt.rcode = ucrr_pkg::REQ_GET_STATUS;
        end else if (pick < 70) begin
            r.pkt.rtype = ucrr_pkg::RT_STD_IN;
            r.pkt.rcode = ucrr_pkg::REQ_GET_DESC;
            pick = $urandom_range(99);
            if (pick < 45) r.pkt.req_value = ucrr_pkg::DESC_DEVICE;
            else if (pick < 90) r.pkt.req_value = ucrr_pkg::DESC_CONFIG;
            pick = $urandom_range(99);
            if (pick < 60) r.pkt.req_length = 16'($urandom_range(40));
            else if (pick < 75) r.pkt.req_length = 16'($urandom_range(3));
        end else if (pick < 80) begin
            r.pkt.rtype = ucrr_pkg::RT_STD_OUT;
            r.pkt.rcode = ucrr_pkg::REQ_SET_CONFIG;
            if ($urandom_range(99) < 70) r.pkt.req_value = 16'h0000;
        end
        return r;
    endfunction

    // offer one setup transfer after random gaps and hold it until taken
    task automatic send_row(input t_row r);
        while (!no_gaps && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_row = r;
        i_in_valid       <= 1'b1;
        i_command        <= r.pkt.cmd;
        i_request_type   <= r.pkt.rtype;
        i_request_code   <= r.pkt.rcode;
        i_request_value  <= r.pkt.req_value;
        i_request_length <= r.pkt.req_length;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every answer is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // program vendor, product and release ids
    task automatic write_ids(input ucrr_pkg::t_dev_ids ids);
        ucrr_pkg::t_cfg_idx idx;
        for (idx = ucrr_pkg::CFG_VENDOR; idx <= ucrr_pkg::CFG_RELEASE; idx++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                ucrr_pkg::CFG_VENDOR:  i_cfg_data <= ids.vendor_id;
                ucrr_pkg::CFG_PRODUCT: i_cfg_data <= ids.product_id;
                default:               i_cfg_data <= ids.device_release;
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        int unsigned        phase;
        int unsigned        k;
        ucrr_pkg::t_dev_ids ids;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = 1'b0;
        i_request_type   = '0;
        i_request_code   = '0;
        i_request_value  = '0;
        i_request_length = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = ucrr_pkg::CFG_VENDOR;
        i_cfg_data       = '0;
        cur_row          = '0;
        mismatches       = 0;
        no_gaps          = 1'b0;
        hold_request     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at reset ids
        for (k = 0; k < DIRECTED_ROWS; k++) send_row(directed_row(k));

        // random part, new ids each phase
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: ids = '0;
                1: ids = '1;
                default: begin
                    ids.vendor_id      = 16'($urandom);
                    ids.product_id     = 16'($urandom);
                    ids.device_release = 16'($urandom);
                end
            endcase
            write_ids(ids);
            no_gaps = (phase == 3);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 1 && k == 10) hold_request = 1'b1;
                if (phase == 2 && k == ITEMS_PER_PHASE / 2) settle();
                send_row(random_row());
            end
            no_gaps = 1'b0;
        end
        settle();

        if (mismatches == 0) begin
            $display("usb_control_request_responder_unit regression: pass");
        end else begin
            $display("usb_control_request_responder_unit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("usb_control_request_responder_unit regression: fail");
        $finish;
    end

endmodule
